### sv/lkvc_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the lru key-value cache
// no dependencies
package lkvc_pkg;

	localparam int KEY_W           = 32;
	localparam int VAL_W           = 32;
	localparam int ENTRY_W         = KEY_W + VAL_W;
	localparam int CAP_W           = 5;
	localparam int MAX_ENTRIES_DEF = 16;

	localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	// request kind carried in tuser
	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_SET = 1'b1;

	// lookup answer handed from the sequencer to the output register
	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] data;
	} res_t;

endpackage

### sv/lkvc_store.sv
`timescale 1ns / 1ps
// entry memory: one write port, one read port with registered read data
// depends on lkvc_pkg
module lkvc_store #(
	parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
	parameter int AW          = 4
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [lkvc_pkg::ENTRY_W-1:0] wdata,
	input  logic [AW-1:0]                raddr,
	output logic [lkvc_pkg::ENTRY_W-1:0] rdata
);
	import lkvc_pkg::*;

	logic [ENTRY_W-1:0] mem_q [MAX_ENTRIES];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/lkvc_seq.sv
`timescale 1ns / 1ps
// sequencer: scans the recency chain with one key comparator, then shifts
// entries one position a step to bring the touched key to the front
// depends on lkvc_pkg; drives the ports of lkvc_store
module lkvc_seq #(
	parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
	parameter int AW          = 4,
	parameter int CW          = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic                         req_mode,
	input  logic [lkvc_pkg::KEY_W-1:0]   req_key,
	input  logic [lkvc_pkg::VAL_W-1:0]   req_data,
	input  logic [lkvc_pkg::CAP_W-1:0]   capacity,
	input  logic                         res_free,
	output logic                         res_valid,
	output lkvc_pkg::res_t               res,
	output logic                         mem_we,
	output logic [AW-1:0]                mem_waddr,
	output logic [lkvc_pkg::ENTRY_W-1:0] mem_wdata,
	output logic [AW-1:0]                mem_raddr,
	input  logic [lkvc_pkg::ENTRY_W-1:0] mem_rdata
);
	import lkvc_pkg::*;

	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_DECIDE,
		S_RESULT,
		S_MRD,
		S_MWR,
		S_FRONT
	} state_t;

	state_t             state_q;
	logic               mode_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;
	logic [AW-1:0]      idx_q;
	logic [CW-1:0]      count_q;
	logic               found_q;

	logic [LW-1:0]      live_cap;
	logic [CW-1:0]      keep;
	logic               key_match;
	logic               scan_last;

	// capacity zero acts as one, above the memory depth acts as the depth
	always_comb begin
		live_cap = LW'(capacity);
		if (live_cap == '0) begin
			live_cap = LW'(1);
		end
		if (live_cap > LW'(MAX_ENTRIES)) begin
			live_cap = LW'(MAX_ENTRIES);
		end
		if (LW'(count_q) >= live_cap) begin
			keep = CW'(live_cap - LW'(1));
		end else begin
			keep = count_q;
		end
	end

	assign key_match = (mem_rdata[ENTRY_W-1 -: KEY_W] == key_q);
	assign scan_last = ((CW'(idx_q) + CW'(1)) == count_q);

	always_comb begin
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		unique case (state_q)
			S_RD:    mem_raddr = idx_q;
			S_MRD:   mem_raddr = idx_q - AW'(1);
			S_MWR:   mem_we = 1'b1;
			S_FRONT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = {key_q, val_q};
			end
			default: ;
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESULT) && res_free;
	assign res.hit   = found_q;
	assign res.data  = found_q ? val_q : MISS_VALUE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			found_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						mode_q  <= req_mode;
						key_q   <= req_key;
						val_q   <= req_data;
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= (count_q == '0) ? S_DECIDE : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (key_match) begin
						found_q <= 1'b1;
						if (mode_q == MODE_GET) begin
							val_q <= mem_rdata[VAL_W-1:0];
						end
						state_q <= S_DECIDE;
					end else if (scan_last) begin
						state_q <= S_DECIDE;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_RD;
					end
				end
				S_DECIDE: begin
					if (mode_q == MODE_GET) begin
						state_q <= S_RESULT;
					end else if (found_q) begin
						state_q <= (idx_q == '0) ? S_FRONT : S_MRD;
					end else begin
						// absent key: drop the tail beyond capacity-1, insert in front
						idx_q   <= AW'(keep);
						count_q <= keep + CW'(1);
						state_q <= (keep == '0) ? S_FRONT : S_MRD;
					end
				end
				S_RESULT: begin
					if (res_free) begin
						if (!found_q) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= (idx_q == '0) ? S_FRONT : S_MRD;
						end
					end
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					idx_q   <= idx_q - AW'(1);
					state_q <= (idx_q == AW'(1)) ? S_FRONT : S_MRD;
				end
				S_FRONT: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### sv/lru_key_value_cache_unit.sv
`timescale 1ns / 1ps
// top level of the lru key-value cache: stream ports, capacity register,
// output register; depends on lkvc_pkg, lkvc_seq and lkvc_store
//
// usage
//   s_* carries requests: s_tuser is the mode (get or set), s_tdata holds the
//   key and, for a set, the value. a get returns one result on m_*: m_tuser is
//   the hit flag, m_tdata the stored value or all ones on a miss. a set
//   returns nothing.
//   capacity_we/capacity_wdata write the capacity register; write it only
//   while no request is in flight.
// timing
//   one request at a time. a request reads and compares the entries in turn up
//   to a hit (or the whole chain on a miss) through the single key comparator
//   and the registered memory read, then, unless a get misses, shifts each entry
//   ahead of the key back one position to bring the key to the front; a get
//   offers its result before the shift.
// reset
//   arst_n clears the entry count and the busy state and sets capacity to 16;
//   the entry memory itself is not cleared, only counted entries are read.
// stalls
//   the result sits in an output register; a stalled receiver holds it, and a
//   following get waits in the sequencer until that register frees up.
module lru_key_value_cache_unit #(
	parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// request channel
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [63:0]                s_tdata,   // [31:0] key, [63:32] data_in
	input  logic                       s_tuser,   // [0] mode
	// result channel
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,   // [31:0] data_out
	output logic                       m_tuser,   // [0] hit
	// capacity register
	input  logic                       capacity_we,
	input  logic [lkvc_pkg::CAP_W-1:0] capacity_wdata
);
	import lkvc_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic [CAP_W-1:0]   capacity_q;
	logic               m_tvalid_q;
	logic [VAL_W-1:0]   m_tdata_q;
	logic               m_tuser_q;

	logic               res_free;
	logic               res_valid;
	res_t               res;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;

	// capacity register, to be written only when idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (capacity_we) begin
			capacity_q <= capacity_wdata;
		end
	end

	// output register frees when empty or being taken this cycle
	assign res_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_tdata_q <= res.data;
			m_tuser_q <= res.hit;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	lkvc_seq #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.AW          (AW),
		.CW          (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_mode  (s_tuser),
		.req_key   (s_tdata[KEY_W-1:0]),
		.req_data  (s_tdata[KEY_W +: VAL_W]),
		.capacity  (capacity_q),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	lkvc_store #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.AW          (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for lru_key_value_cache_unit: a scripted table, then random get/set
// traffic over a range of capacities, checked against the table's typed answers or a
// recency-chain predictor; depends on lkvc_pkg and lru_key_value_cache_unit
module tb_top;
	import lkvc_pkg::*;

	localparam int          CHAIN_DEPTH  = MAX_ENTRIES_DEF;
	localparam int          PHASES       = 9;
	localparam int          PHASE_ITEMS  = 100;
	localparam int          SETTLE_TICKS = 160;  // longest set: full chain scan and shift
	localparam int          HOLD_AT      = 200;  // results seen before the long hold-off
	localparam int          HOLD_TICKS   = 400;
	localparam int          POOL_N       = 12;
	localparam logic [31:0] KEY_MIN      = 32'h8000_0000;
	localparam logic [31:0] KEY_MAX      = 32'h7fff_ffff;
	localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;
	localparam int          PHASE_CAP [7] = '{16, 1, 4, 16, 3, 15, 2};

	typedef enum logic {ROW_REQUEST, ROW_CAPACITY} row_kind_t;

	// value doubles as the capacity on a capacity row
	typedef struct {
		row_kind_t   kind;
		logic        mode;
		logic [31:0] key;
		logic [31:0] value;
		bit          typed;
		logic        hit;
		logic [31:0] data;
	} script_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [63:0]         s_tdata = '0;
	logic                s_tuser = MODE_GET;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [31:0]         m_tdata;
	logic                m_tuser;
	logic                capacity_we = 1'b0;
	logic [CAP_W-1:0]    capacity_wdata = '0;

	// predictor state: recency chain, front is most recent
	logic [31:0]         chain_keys [CHAIN_DEPTH];
	logic [31:0]         chain_vals [CHAIN_DEPTH];
	int                  chain_len = 0;
	int                  capacity_now = int'(CAP_RESET);

	res_t                pending_results [$];
	logic [31:0]         key_pool [POOL_N];
	int                  mismatches = 0;
	int                  results_seen = 0;
	bit                  burst_mode = 1'b0;

	script_row_t script [22] = '{
		'{ROW_REQUEST,  MODE_GET, 32'h0,        32'h0,        1'b1, 1'b0, MISS_VALUE},
		'{ROW_REQUEST,  MODE_GET, KEY_MIN,      32'h0,        1'b1, 1'b0, MISS_VALUE},
		'{ROW_REQUEST,  MODE_SET, KEY_MAX,      KEY_MIN,      1'b0, 1'b0, 32'h0},
		'{ROW_REQUEST,  MODE_GET, KEY_MAX,      32'h0,        1'b1, 1'b1, KEY_MIN},
		'{ROW_REQUEST,  MODE_SET, KEY_MIN,      KEY_MAX,      1'b0, 1'b0, 32'h0},
		'{ROW_REQUEST,  MODE_GET, KEY_MIN,      32'h0,        1'b1, 1'b1, KEY_MAX},
		'{ROW_REQUEST,  MODE_SET, ALL_ONES,     ALL_ONES,     1'b0, 1'b0, 32'h0},
		'{ROW_REQUEST,  MODE_GET, ALL_ONES,     32'h0,        1'b1, 1'b1, ALL_ONES},
		// overwrite of a present key
		'{ROW_REQUEST,  MODE_SET, KEY_MAX,      32'h0,        1'b0, 1'b0, 32'h0},
		'{ROW_REQUEST,  MODE_GET, KEY_MAX,      32'h0,        1'b1, 1'b1, 32'h0},
		// data field ignored on a get
		'{ROW_REQUEST,  MODE_GET, 32'h0,        32'h5a5a5a5a, 1'b1, 1'b0, MISS_VALUE},
		// capacity dropped under the count: old entries still found
		'{ROW_CAPACITY, MODE_GET, 32'h0,        32'd2,        1'b0, 1'b0, 32'h0},
		'{ROW_REQUEST,  MODE_GET, KEY_MIN,      32'h0,        1'b1, 1'b1, KEY_MAX},
		'{ROW_REQUEST,  MODE_GET, ALL_ONES,     32'h0,        1'b1, 1'b1, ALL_ONES},
		'{ROW_REQUEST,  MODE_SET, 32'h1,        32'h11111111, 1'b0, 1'b0, 32'h0},
		'{ROW_REQUEST,  MODE_GET, KEY_MIN,      32'h0,        1'b0, 1'b0, 32'h0},
		'{ROW_REQUEST,  MODE_GET, KEY_MAX,      32'h0,        1'b0, 1'b0, 32'h0},
		'{ROW_CAPACITY, MODE_GET, 32'h0,        32'd1,        1'b0, 1'b0, 32'h0},
		'{ROW_REQUEST,  MODE_SET, 32'h2,        32'h22222222, 1'b0, 1'b0, 32'h0},
		'{ROW_REQUEST,  MODE_GET, 32'h1,        32'h0,        1'b0, 1'b0, 32'h0},
		'{ROW_REQUEST,  MODE_GET, 32'h2,        32'h0,        1'b0, 1'b0, 32'h0},
		'{ROW_CAPACITY, MODE_GET, 32'h0,        32'd16,       1'b0, 1'b0, 32'h0}
	};

	lru_key_value_cache_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// move the entry at pos to the front of the chain
	function automatic void promote(input int pos);
		logic [31:0] k;
		logic [31:0] v;
		k = chain_keys[pos];
		v = chain_vals[pos];
		for (int i = pos; i > 0; i--) begin
			chain_keys[i] = chain_keys[i-1];
			chain_vals[i] = chain_vals[i-1];
		end
		chain_keys[0] = k;
		chain_vals[0] = v;
	endfunction

	// one request against the chain; answers only for a get
	function automatic bit cache_access(input logic mode, input logic [31:0] key,
			input logic [31:0] value, output res_t answer);
		int pos;
		int keep;
		int cap;
		pos = -1;
		for (int i = 0; i < chain_len; i++) begin
			if (pos < 0 && chain_keys[i] == key) pos = i;
		end
		answer.hit = 1'b0;
		answer.data = MISS_VALUE;
		if (mode == MODE_GET) begin
			if (pos >= 0) begin
				answer.hit = 1'b1;
				answer.data = chain_vals[pos];
				promote(pos);
			end
			return 1'b1;
		end
		if (pos >= 0) begin
			chain_vals[pos] = value;
			promote(pos);
		end else begin
			cap = capacity_now < 1 ? 1 : (capacity_now > CHAIN_DEPTH ? CHAIN_DEPTH : capacity_now);
			keep = chain_len >= cap ? cap - 1 : chain_len;
			for (int i = keep; i > 0; i--) begin
				chain_keys[i] = chain_keys[i-1];
				chain_vals[i] = chain_vals[i-1];
			end
			chain_keys[0] = key;
			chain_vals[0] = value;
			chain_len = keep + 1;
		end
		return 1'b0;
	endfunction

	// offer one request after a random gap (none in burst mode), predict once it is taken
	task automatic send_request(input logic mode, input logic [31:0] key,
			input logic [31:0] value, output bit answers, output res_t answer);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {value, key};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		answers = cache_access(mode, key, value, answer);
	endtask

	// wait for every answer, then for any set still walking the chain
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_capacity(input int cap);
		capacity_we <= 1'b1;
		capacity_wdata <= CAP_W'(cap);
		@(posedge clk);
		capacity_we <= 1'b0;
		capacity_now = cap;
	endtask

	// mostly keys already cached, so hits land at every depth
	function automatic logic [31:0] pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (chain_len > 0 && sel < 5) return chain_keys[$urandom_range(0, chain_len - 1)];
		if (sel < 8) return key_pool[$urandom_range(0, POOL_N - 1)];
		return $urandom();
	endfunction

	function automatic logic [31:0] pick_value();
		int sel;
		sel = $urandom_range(0, 7);
		if (sel == 0) return KEY_MIN;
		if (sel == 1) return KEY_MAX;
		if (sel == 2) return ALL_ONES;
		return $urandom();
	endfunction

	// request side: reset, scripted table, random phases, verdict
	initial begin
		bit   answers;
		res_t answer;
		res_t typed_answer;
		logic mode;
		int   cap;

		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = ALL_ONES;
		key_pool[3] = 32'h0;
		for (int i = 4; i < POOL_N; i++) key_pool[i] = $urandom();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[r]) begin
			if (script[r].kind == ROW_CAPACITY) begin
				settle();
				write_capacity(int'(script[r].value));
			end else begin
				send_request(script[r].mode, script[r].key, script[r].value, answers, answer);
				if (answers) begin
					typed_answer.hit = script[r].hit;
					typed_answer.data = script[r].data;
					pending_results.push_back(script[r].typed ? typed_answer : answer);
				end
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				settle();
				cap = ph < 7 ? PHASE_CAP[ph] : $urandom_range(1, CHAIN_DEPTH);
				write_capacity(cap);
			end
			// some phases run back to back on both sides
			burst_mode = (ph % 3 == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				mode = ($urandom_range(0, 99) < 55) ? MODE_GET : MODE_SET;
				send_request(mode, pick_key(), pick_value(), answers, answer);
				if (answers) pending_results.push_back(answer);
			end
		end

		settle();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// result side: random ready gaps, one long hold-off, compare against the oldest answer
	initial begin
		int   gap;
		bit   held;
		res_t want;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (results_seen == HOLD_AT && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_TICKS) @(posedge clk);
			end else begin
				gap = burst_mode ? 0 : $urandom_range(0, 8);
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			results_seen++;
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("result with no request waiting: hit %b data %h",
					m_tuser, m_tdata));
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.hit)
					flag_mismatch($sformatf("hit %b, wanted %b", m_tuser, want.hit));
				if (m_tdata !== want.data)
					flag_mismatch($sformatf("data %h, wanted %h", m_tdata, want.data));
			end
		end
	end

endmodule

### files.f
sv/lkvc_pkg.sv
sv/lkvc_store.sv
sv/lkvc_seq.sv
sv/lru_key_value_cache_unit.sv
dv/tb_top.sv
